// ===== src/cpts_pkg.sv =====
// ----------------------------------------------------------------------------
// cpts_pkg
// Types, codes and constants of the prefetch target select unit.
// ----------------------------------------------------------------------------
package cpts_pkg;

   localparam int CPTS_MAX_ITEMS = 64;
   localparam int CPTS_SIZE_BITS = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FILES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_MB  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AHEAD_WEIGHT = 2'd2;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SELECT = 1'b1;

   typedef enum logic [1:0] {
      KIND_FETCH = 2'd0,
      KIND_EVICT = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_GEN   = 5'b00010,
      ST_RANGE = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic        mode;
      logic [5:0]  entry_index;
      logic [15:0] entry_size_mb;
      logic        entry_cached;
      logic [5:0]  current_key;
   } req_payload_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] item_key;
      logic [5:0] target_first;
      logic [5:0] target_last;
      logic       forward;
      logic       last;
   } rsp_payload_type;

   // ahead run length per strategy code
   function automatic logic [6:0] run_length(input logic [3:0] weight);
      logic [6:0] run;
      unique case (weight)
         4'd6:    run = 7'd3;
         4'd7:    run = 7'd2;
         4'd8:    run = 7'd4;
         4'd9:    run = 7'd8;
         4'd10:   run = 7'd100;
         default: run = 7'd1;
      endcase
      return run;
   endfunction

endpackage

// ===== src/cpts_stream_if.sv =====
// ----------------------------------------------------------------------------
// cpts_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface cpts_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cpts_ram.sv =====
// ----------------------------------------------------------------------------
// cpts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cpts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== src/cache_prefetch_target_select_unit.sv =====
// ----------------------------------------------------------------------------
// cache_prefetch_target_select_unit
// Ranks list items around the current position and emits fetch and evict
// requests so that the targeted items fit in the cache capacity.
// ----------------------------------------------------------------------------
// Usage:
//  req_if  : table write (mode 0) or select (mode 1) requests.
//  rsp_if  : fetch / evict / nothing-to-do requests of a select; last marks
//            the final one. A table write produces nothing.
//  csr_*   : total_files, capacity_mb, ahead_weight; write only while idle.
// Operation:
//  table write : req_if.ready stays high.
//  select      : ranking and summing (one size RAM read a cycle), finding
//                the target range, then a scan of the priority RAM,
//                fetches forwards then evicts backwards; one select at a
//                time.
// A result is held in the output register until rsp_if.ready; the scan
// waits meanwhile. req_if.ready is low from select accept until the final
// result is taken.
// Reset: direction forward, previous position -1, hysteresis count and
// target range zero, all written flags clear so items count as uncached.
// Sizes are undefined until written.
// ----------------------------------------------------------------------------
module cache_prefetch_target_select_unit import cpts_pkg::*; #(
   parameter int MAX_ITEMS = CPTS_MAX_ITEMS,
   parameter int SIZE_BITS = CPTS_SIZE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   cpts_stream_if.sink           req_if,
   cpts_stream_if.source         rsp_if
);
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SW    = CNT_W + 1;
   localparam int SUM_W = SIZE_BITS + IDX_W + 1;
   localparam int CMP_W = (SUM_W > 16) ? SUM_W : 16;
   localparam int OW    = IDX_W + 2;

   // configuration
   logic [6:0]  total_files_ff;
   logic [15:0] capacity_ff;
   logic [3:0]  weight_ff;

   // control and sequencer state
   state_type          state_ff, state_in;
   logic signed [6:0]  prev_ff, prev_in;
   logic               fwd_ff, fwd_in;
   logic signed [1:0]  tc_ff, tc_in;
   logic [IDX_W-1:0]   rf_ff, rf_in, rl_ff, rl_in;
   logic [MAX_ITEMS-1:0] written_ff, written_in;
   logic [MAX_ITEMS-1:0] tgt_ff, tgt_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [7:0]  a_ff, a_in, b_ff, b_in;
   logic [6:0]         run_i_ff, run_i_in;
   logic               g_valid_ff, g_valid_in;
   logic [IDX_W-1:0]   g_key_ff, g_key_in, g_pos_ff, g_pos_in;
   logic               g_wr_ff, g_wr_in;
   logic [CMP_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   nf_ff, nf_in, ne_ff, ne_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic               found_ff, found_in, gap_ff, gap_in;
   logic [SW-1:0]      s_ff, s_in, chk_s_ff, chk_s_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]   em_ff, em_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [IDX_W-1:0]   out_key_ff, out_key_in;
   logic               out_last_ff, out_last_in;

   // RAM ports
   logic                 size_we;
   logic [IDX_W-1:0]     size_waddr, size_raddr;
   logic [SIZE_BITS:0]   size_wdata, size_rdata;
   logic                 order_we;
   logic [IDX_W-1:0]     order_raddr;
   logic [OW-1:0]        order_wdata, order_rdata;

   // combinational helpers
   req_payload_type    rq;
   logic               req_acc;
   logic [6:0]         n7, nm1, key7;
   logic [CNT_W-1:0]   n_c;
   logic [IDX_W-1:0]   k_c, idx_c;
   logic signed [7:0]  kk, pv, step_c;
   logic signed [2:0]  tsum;
   logic               latest, adj, fwd_c;
   logic signed [1:0]  tc_c;
   logic [6:0]         run_c;
   logic               a_ok, b_ok, take_a;
   logic [CMP_W-1:0]   sum_n;
   logic               is_t, is_c;
   logic [SW-1:0]      n_s, pos_s;
   logic [CNT_W:0]     total_c;
   logic               ord_t, ord_c, ph, match;

   assign rq      = req_if.data;
   assign req_acc = req_if.valid && req_if.ready;

   // item count saturated into 1..MAX_ITEMS, key saturated to last item
   assign n7    = (total_files_ff == 7'd0) ? 7'd1 :
                  (total_files_ff > 7'(MAX_ITEMS)) ? 7'(MAX_ITEMS) : total_files_ff;
   assign n_c   = CNT_W'(n7);
   assign nm1   = n7 - 7'd1;
   assign key7  = {1'b0, rq.current_key};
   assign k_c   = IDX_W'((key7 > nm1) ? nm1 : key7);
   assign idx_c = IDX_W'(rq.entry_index);

   // direction hysteresis
   assign kk     = $signed(8'(k_c));
   assign pv     = {prev_ff[6], prev_ff};
   assign latest = kk > pv;
   assign adj    = !((kk > pv + 8'sd1) || (kk < pv - 8'sd1));
   assign tsum   = {tc_ff[1], tc_ff} + (latest ? 3'sd1 : 3'sb111);

   always_comb begin
      fwd_c = fwd_ff;
      tc_c  = tc_ff;
      if (adj) begin
         if ((tsum > 3'sd1) || (tsum < 3'sb111)) begin
            fwd_c = latest;
            tc_c  = 2'sd0;
         end else begin
            tc_c = tsum[1:0];
         end
      end else begin
         fwd_c = latest;
      end
      if (k_c == '0) fwd_c = 1'b1;
      if (7'(k_c) == nm1) fwd_c = 1'b0;
   end

   // ranking helpers
   assign run_c  = run_length(weight_ff);
   assign step_c = fwd_ff ? 8'sd1 : -8'sd1;
   assign a_ok   = !a_ff[7] && (a_ff[6:0] < n7);
   assign b_ok   = !b_ff[7] && (b_ff[6:0] < n7);
   assign take_a = a_ok && ((run_i_ff < run_c) || !b_ok);

   // size accumulation of the item read last cycle
   assign sum_n = sum_ff + CMP_W'(size_rdata[SIZE_BITS-1:0]);
   assign is_t  = sum_n < CMP_W'(capacity_ff);
   assign is_c  = g_wr_ff & size_rdata[SIZE_BITS];

   // scan: fetch positions 0..n-1, then evict positions n-1..0
   assign n_s     = SW'(n_c);
   assign pos_s   = (s_ff < n_s) ? s_ff : (({n_s[SW-2:0], 1'b0}) - SW'(1) - s_ff);
   assign total_c = {1'b0, nf_ff} + {1'b0, ne_ff};
   assign ord_t   = order_rdata[IDX_W+1];
   assign ord_c   = order_rdata[IDX_W];
   assign ph      = chk_s_ff >= n_s;
   assign match   = ph ? (!ord_t && ord_c) : (ord_t && !ord_c);

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      fwd_in       = fwd_ff;
      tc_in        = tc_ff;
      rf_in        = rf_ff;
      rl_in        = rl_ff;
      written_in   = written_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      run_i_in     = run_i_ff;
      g_valid_in   = 1'b0;
      g_key_in     = g_key_ff;
      g_pos_in     = g_pos_ff;
      g_wr_in      = g_wr_ff;
      sum_in       = sum_ff;
      nf_in        = nf_ff;
      ne_in        = ne_ff;
      j_in         = j_ff;
      found_in     = found_ff;
      gap_in       = gap_ff;
      s_in         = s_ff;
      chk_s_in     = chk_s_ff;
      chk_valid_in = 1'b0;
      em_in        = em_ff;
      out_kind_in  = out_kind_ff;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;
      size_we      = 1'b0;
      size_waddr   = idx_c;
      size_wdata   = {rq.entry_cached, SIZE_BITS'(rq.entry_size_mb)};
      size_raddr   = g_key_ff;
      order_we     = 1'b0;
      order_wdata  = {is_t, is_c, g_key_ff};
      order_raddr  = IDX_W'(pos_s);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (rq.mode == MODE_WRITE) begin
                  if ({1'b0, rq.entry_index} < 7'(MAX_ITEMS)) begin
                     size_we           = 1'b1;
                     written_in[idx_c] = 1'b1;
                  end
               end else begin
                  prev_in    = $signed(7'(k_c));
                  fwd_in     = fwd_c;
                  tc_in      = tc_c;
                  a_in       = kk + (fwd_c ? 8'sd1 : -8'sd1);
                  b_in       = kk - (fwd_c ? 8'sd1 : -8'sd1);
                  run_i_in   = 7'd0;
                  cnt_in     = CNT_W'(1);
                  g_valid_in = 1'b1;
                  g_key_in   = k_c;
                  g_pos_in   = '0;
                  g_wr_in    = written_ff[k_c];
                  size_raddr = k_c;
                  sum_in     = '0;
                  nf_in      = '0;
                  ne_in      = '0;
                  tgt_in     = '0;
                  state_in   = ST_GEN;
               end
            end
         end
         ST_GEN: begin
            if (cnt_ff < n_c) begin
               g_valid_in = 1'b1;
               g_pos_in   = IDX_W'(cnt_ff);
               cnt_in     = cnt_ff + CNT_W'(1);
               if (take_a) begin
                  g_key_in = IDX_W'(a_ff[6:0]);
                  a_in     = a_ff + step_c;
                  run_i_in = (run_i_ff < run_c) ? run_i_ff + 7'd1 : 7'd1;
               end else begin
                  g_key_in = IDX_W'(b_ff[6:0]);
                  b_in     = b_ff - step_c;
                  run_i_in = 7'd0;
               end
               g_wr_in    = written_ff[g_key_in];
               size_raddr = g_key_in;
            end else begin
               j_in     = '0;
               found_in = 1'b0;
               gap_in   = 1'b0;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (!found_ff) begin
               if (tgt_ff[j_ff]) begin
                  found_in = 1'b1;
                  rf_in    = j_ff;
                  rl_in    = IDX_W'(nm1);
               end
            end else if (!gap_ff && !tgt_ff[j_ff]) begin
               gap_in = 1'b1;
               rl_in  = j_ff - IDX_W'(1);
            end
            j_in = j_ff + IDX_W'(1);
            if (7'(j_ff) == nm1) begin
               em_in = '0;
               if (total_c == '0) begin
                  out_kind_in = KIND_NONE;
                  out_key_in  = '0;
                  out_last_in = 1'b1;
                  state_in    = ST_OUT;
               end else begin
                  s_in     = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (s_ff < {n_s[SW-2:0], 1'b0}) begin
               chk_valid_in = 1'b1;
               chk_s_in     = s_ff;
               s_in         = s_ff + SW'(1);
            end
            if (chk_valid_ff && match) begin
               out_kind_in  = ph ? KIND_EVICT : KIND_FETCH;
               out_key_in   = order_rdata[IDX_W-1:0];
               out_last_in  = ({1'b0, em_ff} == total_c - (CNT_W+1)'(1));
               s_in         = chk_s_ff + SW'(1);
               chk_valid_in = 1'b0;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               em_in    = em_ff + CNT_W'(1);
               state_in = out_last_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // accumulate and record the item whose size arrives this cycle
      if (g_valid_ff) begin
         sum_in           = sum_n;
         order_we         = 1'b1;
         tgt_in[g_key_ff] = is_t;
         if (is_t && !is_c) nf_in = nf_in + CNT_W'(1);
         if (!is_t && is_c) ne_in = ne_in + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_files_ff <= 7'd1;
         capacity_ff    <= 16'd3000;
         weight_ff      <= 4'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_FILES:  total_files_ff <= csr_wdata[6:0];
            CSR_CAPACITY_MB:  capacity_ff    <= csr_wdata;
            CSR_AHEAD_WEIGHT: weight_ff      <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= -7'sd1;
         fwd_ff       <= 1'b1;
         tc_ff        <= 2'sd0;
         rf_ff        <= '0;
         rl_ff        <= '0;
         written_ff   <= '0;
         g_valid_ff   <= 1'b0;
         chk_valid_ff <= 1'b0;
         em_ff        <= '0;
         nf_ff        <= '0;
         ne_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         fwd_ff       <= fwd_in;
         tc_ff        <= tc_in;
         rf_ff        <= rf_in;
         rl_ff        <= rl_in;
         written_ff   <= written_in;
         g_valid_ff   <= g_valid_in;
         chk_valid_ff <= chk_valid_in;
         em_ff        <= em_in;
         nf_ff        <= nf_in;
         ne_ff        <= ne_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      cnt_ff      <= cnt_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      run_i_ff    <= run_i_in;
      g_key_ff    <= g_key_in;
      g_pos_ff    <= g_pos_in;
      g_wr_ff     <= g_wr_in;
      sum_ff      <= sum_in;
      j_ff        <= j_in;
      found_ff    <= found_in;
      gap_ff      <= gap_in;
      s_ff        <= s_in;
      chk_s_ff    <= chk_s_in;
      out_kind_ff <= out_kind_in;
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
   end

   // size and cached flag per item
   cpts_ram #(.WIDTH(SIZE_BITS + 1), .DEPTH(MAX_ITEMS)) u_size_ram (
      .clock (clock),
      .we    (size_we),
      .waddr (size_waddr),
      .wdata (size_wdata),
      .raddr (size_raddr),
      .rdata (size_rdata)
   );

   // priority order: {target, cached, key} per rank
   cpts_ram #(.WIDTH(OW), .DEPTH(MAX_ITEMS)) u_order_ram (
      .clock (clock),
      .we    (order_we),
      .waddr (g_pos_ff),
      .wdata (order_wdata),
      .raddr (order_raddr),
      .rdata (order_rdata)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = (state_ff == ST_OUT);
   always_comb begin
      rsp_if.data.kind         = out_kind_ff;
      rsp_if.data.item_key     = 6'(out_key_ff);
      rsp_if.data.target_first = 6'(rf_ff);
      rsp_if.data.target_last  = 6'(rl_ff);
      rsp_if.data.forward      = fwd_ff;
      rsp_if.data.last         = out_last_ff;
   end

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request accepted while a result is pending");

   a_select_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && rq.mode == MODE_SELECT) |=> (state_ff == ST_GEN))
      else $error("select did not start ranking");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_kind_ff != KIND_NONE) |-> ({1'b0, em_ff} < total_c))
      else $error("more results than fetch and evict candidates");

   a_gen_stage: assert property (@(posedge clock) disable iff (reset)
      g_valid_ff |-> (state_ff == ST_GEN))
      else $error("size accumulation outside ranking");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && out_last_ff) |=> req_if.ready)
      else $error("not idle after final result");

endmodule
